// ===== sv/vaos_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaos_pkg: shared definitions for the voice allocator
// Sizes, event codes and the command and status words that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package vaos_pkg;

    localparam int NUM_VOICES = 16;
    localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int PITCH_W    = 7;
    localparam int VEL_W      = 7;
    localparam int MASK_W     = 16;
    localparam int VOICE_W    = 4;
    localparam int AGE_W      = 64;

    // Voices that have a bit in the silent and released masks.
    localparam int MASKED_N   = (NUM_VOICES < MASK_W) ? NUM_VOICES : MASK_W;

    localparam logic FUNC_NOTE_ON = 1'b0;

    typedef struct packed {
        logic load;    // capture the accepted word and restart the scan
        logic step;    // examine one voice
        logic commit;  // update the voice state and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_note_on;  // word on the input port is a real note-on
        logic scan_last;   // the scan is at the highest voice
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== sv/vaos_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaos_ctrl: sequencing controller
// Accepts one word at a time, runs the voice scan for note-ons and commits
// the result into the output register once that register is free.
// ----------------------------------------------------------------------------
module vaos_ctrl
    import vaos_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   slot_free;

    assign accept    = in_valid && (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.in_note_on ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/vaos_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaos_dp: voice state and allocation datapath
// Holds the voice table and age counter, scans one voice a cycle for the
// first free voice and the oldest stamp, and holds the result register.
// ----------------------------------------------------------------------------
module vaos_dp
    import vaos_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               func,
    input  wire logic [PITCH_W-1:0] pitch,
    input  wire logic [VEL_W-1:0]   velocity,
    input  wire logic [MASK_W-1:0]  silent_mask,
    input  wire ctrl_cmd_t          cmd,
    output ctrl_status_t            status,
    output logic [VOICE_W-1:0]      assigned_voice,
    output logic                    assigned_valid,
    output logic                    was_stolen,
    output logic [MASK_W-1:0]       released_mask
);

    // Voice table. Age entries that were never stamped read as zero.
    logic [NUM_VOICES-1:0] active_reg, active_next;
    logic [NUM_VOICES-1:0] age_ok_reg, age_ok_next;
    logic [PITCH_W-1:0]    vpitch_reg [NUM_VOICES];
    logic [AGE_W-1:0]      vage_reg   [NUM_VOICES];
    logic [AGE_W-1:0]      ctr_reg, ctr_next;

    // Captured event.
    logic                  ev_on_reg;
    logic [PITCH_W-1:0]    ev_pitch_reg;
    logic [MASK_W-1:0]     ev_silent_reg;

    // Scan state.
    logic [VIDX_W-1:0]     idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic [VIDX_W-1:0]     free_idx_reg, free_idx_next;
    logic [AGE_W-1:0]      best_age_reg, best_age_next;
    logic [VIDX_W-1:0]     best_idx_reg, best_idx_next;

    // Result register.
    logic [VOICE_W-1:0]    voice_out_reg;
    logic                  valid_out_reg;
    logic                  stolen_out_reg;
    logic [MASK_W-1:0]     rel_out_reg;

    logic [NUM_VOICES-1:0] silent_ext;
    logic [NUM_VOICES-1:0] rel_full;
    logic [MASK_W-1:0]     rel_mask;
    logic [AGE_W-1:0]      scan_age;
    logic [VIDX_W-1:0]     target;

    always_comb
    begin
        silent_ext = '0;
        for (int v = 0; v < MASKED_N; v++)
        begin
            silent_ext[v] = ev_silent_reg[v];
        end
    end

    always_comb
    begin
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            rel_full[v] = active_reg[v] && (vpitch_reg[v] == ev_pitch_reg);
        end
        rel_mask = '0;
        for (int b = 0; b < MASKED_N; b++)
        begin
            rel_mask[b] = rel_full[b];
        end
    end

    assign scan_age = age_ok_reg[idx_reg] ? vage_reg[idx_reg] : '0;
    assign target   = found_reg ? free_idx_reg : best_idx_reg;
    assign ctr_next = ctr_reg + AGE_W'(1);

    assign status.in_note_on = (func == FUNC_NOTE_ON) && (velocity != '0);
    assign status.scan_last  = (idx_reg == VIDX_W'(NUM_VOICES - 1));

    always_comb
    begin
        idx_next      = idx_reg;
        found_next    = found_reg;
        free_idx_next = free_idx_reg;
        best_age_next = best_age_reg;
        best_idx_next = best_idx_reg;
        if (cmd.load)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.step)
        begin
            idx_next = idx_reg + VIDX_W'(1);
            if (!found_reg && !active_reg[idx_reg] && silent_ext[idx_reg])
            begin
                found_next    = 1'b1;
                free_idx_next = idx_reg;
            end
            // Strict compare keeps the lowest voice on equal stamps.
            if ((idx_reg == '0) || (scan_age < best_age_reg))
            begin
                best_age_next = scan_age;
                best_idx_next = idx_reg;
            end
        end
    end

    always_comb
    begin
        active_next = active_reg;
        age_ok_next = age_ok_reg;
        if (cmd.commit)
        begin
            if (ev_on_reg)
            begin
                active_next[target] = 1'b1;
                age_ok_next[target] = 1'b1;
            end
            else
            begin
                active_next = active_reg & ~rel_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            age_ok_reg <= '0;
            ctr_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            age_ok_reg <= age_ok_next;
            if (cmd.commit && ev_on_reg)
            begin
                ctr_reg <= ctr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        found_reg    <= found_next;
        free_idx_reg <= free_idx_next;
        best_age_reg <= best_age_next;
        best_idx_reg <= best_idx_next;
        if (cmd.load)
        begin
            ev_on_reg     <= status.in_note_on;
            ev_pitch_reg  <= pitch;
            ev_silent_reg <= silent_mask;
        end
        if (cmd.commit)
        begin
            if (ev_on_reg)
            begin
                vpitch_reg[target] <= ev_pitch_reg;
                vage_reg[target]   <= ctr_next;
                voice_out_reg      <= VOICE_W'(target);
                valid_out_reg      <= 1'b1;
                stolen_out_reg     <= !found_reg;
                rel_out_reg        <= '0;
            end
            else
            begin
                voice_out_reg  <= '0;
                valid_out_reg  <= 1'b0;
                stolen_out_reg <= 1'b0;
                rel_out_reg    <= rel_mask;
            end
        end
    end

    assign assigned_voice = voice_out_reg;
    assign assigned_valid = valid_out_reg;
    assign was_stolen     = stolen_out_reg;
    assign released_mask  = rel_out_reg;

endmodule

`default_nettype wire

// ===== sv/voice_allocator_oldest_steal.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voice_allocator_oldest_steal: polyphonic voice allocator
// Assigns note-ons to voices, stealing the oldest when none is free, and
// releases every active voice holding the pitch of a note-off.
// ----------------------------------------------------------------------------
// The block takes one note event word at a time. A note-on (non-zero
// velocity) walks the voice table one voice per cycle through a single
// 64-bit age comparator, looking at the same time for the lowest voice that
// is inactive and silent and for the oldest stamp; the word is captured on
// acceptance, the scan then steps through every voice, and the result is
// committed once the output register is free. A note-off, or a note-on of
// zero velocity, compares all stored pitches at once and needs no scan. The
// result goes into an output register, so a new word is accepted in the
// cycle after the commit even while that result still waits to be taken;
// the commit of the following word waits only if the output register is
// then still full. Released voices are reported as a mask, and a stolen
// voice is flagged.
// ----------------------------------------------------------------------------
module voice_allocator_oldest_steal
    import vaos_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               func,
    input  wire logic [PITCH_W-1:0] pitch,
    input  wire logic [VEL_W-1:0]   velocity,
    input  wire logic [MASK_W-1:0]  silent_mask,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [VOICE_W-1:0]      assigned_voice,
    output logic                    assigned_valid,
    output logic                    was_stolen,
    output logic [MASK_W-1:0]       released_mask
);

    // Commands from the controller and scan status back from the datapath.
    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    // The controller owns the handshakes and the order of the work.
    vaos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the voice table, the age counter and the result.
    vaos_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .func           (func),
        .pitch          (pitch),
        .velocity       (velocity),
        .silent_mask    (silent_mask),
        .cmd            (cmd),
        .status         (status),
        .assigned_voice (assigned_voice),
        .assigned_valid (assigned_valid),
        .was_stolen     (was_stolen),
        .released_mask  (released_mask)
    );

endmodule

`default_nettype wire

// ===== sv/vaos_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vaos_chk: port checker for the voice allocator
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module vaos_chk
    import vaos_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [VOICE_W-1:0] assigned_voice,
    input wire logic               assigned_valid,
    input wire logic               was_stolen,
    input wire logic [MASK_W-1:0]  released_mask
);

    // A result held back keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(assigned_voice)
            && $stable(assigned_valid) && $stable(was_stolen)
            && $stable(released_mask))
        else $error("result changed while stalled");

    // Once a word is taken the block is busy in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not held off after acceptance");

    // A new result only follows a word that was being worked on.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no word in work");

    // A release result carries no voice and no steal flag.
    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !assigned_valid |-> !was_stolen && (assigned_voice == '0))
        else $error("release result carries assignment fields");

    // An assignment result carries no released voices.
    a_assign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned_valid |-> (released_mask == '0))
        else $error("assignment result carries released voices");

endmodule

bind voice_allocator_oldest_steal vaos_chk u_vaos_chk (.*);

`default_nettype wire
